// ===== rtl/sbae_pkg.sv =====
// ----------------------------------------------------------------------------
// Segwit address encoder package
// Shared types, codes, constants and small functions: transaction payloads,
// the charset, the bech32 polymod step and the prefix check.
// ----------------------------------------------------------------------------
`default_nettype none

package sbae_pkg;

   // Input transaction: start with version, or one program byte
   typedef struct packed {
      logic       command;
      logic [7:0] value;
      logic       final_byte;
   } req_type;

   // Result transaction: one ASCII character of the address
   typedef struct packed {
      logic [6:0] character;
      logic       end_of_address;
      logic [2:0] status;
   } rsp_type;

   // Configuration seen by the sequencer
   typedef struct packed {
      logic [63:0] prefix_characters;
      logic [3:0]  prefix_length;
      logic        prefix_ok;
   } cfg_type;

   // Sequencer phases
   typedef enum logic [3:0] {
      PH_FIRST,
      PH_START_HI,
      PH_START_SEP,
      PH_START_LO,
      PH_START_ONE,
      PH_START_VER,
      PH_GROUP,
      PH_PAD,
      PH_ZERO,
      PH_CHECK
   } phase_type;

   // Commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // Register indexes
   localparam logic CSR_PREFIX_CHARACTERS = 1'b0;
   localparam logic CSR_PREFIX_LENGTH     = 1'b1;

   // Status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_PREFIX  = 3'd1;
   localparam logic [2:0] ST_BAD_VERSION = 3'd2;
   localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
   localparam logic [2:0] ST_NO_START    = 3'd4;

   // Limits and sizes
   localparam int         PREFIX_SLOTS       = 8;
   localparam logic [3:0] MAX_PREFIX_LENGTH  = 4'd8;
   localparam logic [7:0] MAX_VERSION        = 8'd16;
   localparam logic [5:0] MAX_PROGRAM_BYTES  = 6'd40;
   localparam logic [5:0] MIN_PROGRAM_BYTES  = 6'd2;
   localparam logic [5:0] V0_LENGTH_SHORT    = 6'd20;
   localparam logic [5:0] V0_LENGTH_LONG     = 6'd32;
   localparam logic [5:0] BYTE_COUNT_MAX     = 6'd63;
   localparam logic [3:0] BYTE_BITS          = 4'd8;
   localparam logic [3:0] GROUP_BITS         = 4'd5;
   localparam logic [2:0] CHECK_LAST         = 3'd5;

   // ASCII
   localparam logic [7:0] ASCII_FIRST_PRINT = 8'd33;
   localparam logic [7:0] ASCII_LAST_PRINT  = 8'd126;
   localparam logic [7:0] ASCII_UPPER_A     = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z     = 8'h5a;
   localparam logic [6:0] SEPARATOR_CHAR    = 7'h31;
   localparam logic [6:0] NULL_CHAR         = 7'h00;

   // Reset configuration: "bc"
   localparam logic [63:0] RESET_PREFIX     = 64'h6362;
   localparam logic [3:0]  RESET_PREFIX_LEN = 4'd2;

   // Checksum
   localparam logic [29:0] CHK_INIT      = 30'h1;
   localparam logic [29:0] BECH32_CONST  = 30'h1;
   localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;
   localparam logic [29:0] GEN_0         = 30'h3b6a57b2;
   localparam logic [29:0] GEN_1         = 30'h26508e6d;
   localparam logic [29:0] GEN_2         = 30'h1ea119fa;
   localparam logic [29:0] GEN_3         = 30'h3d4233dd;
   localparam logic [29:0] GEN_4         = 30'h2a1462b3;

   // First character sits in the top byte
   localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   function automatic logic [6:0] charset_char(input logic [4:0] grp);
      logic [4:0] slot;
      slot = 5'd31 - grp;
      return CHARSET[{slot, 3'd0} +: 7];
   endfunction

   function automatic logic [29:0] polymod_feed(input logic [29:0] chk,
                                                input logic [4:0]  v);
      logic [4:0]  top;
      logic [29:0] res;
      top = chk[29:25];
      res = {chk[24:0], 5'd0} ^ {25'd0, v};
      res = res ^ ({30{top[0]}} & GEN_0);
      res = res ^ ({30{top[1]}} & GEN_1);
      res = res ^ ({30{top[2]}} & GEN_2);
      res = res ^ ({30{top[3]}} & GEN_3);
      res = res ^ ({30{top[4]}} & GEN_4);
      return res;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [63:0] chars,
                                              input logic [2:0]  idx);
      return chars[{idx, 3'd0} +: 8];
   endfunction

   function automatic logic prefix_valid(input logic [63:0] chars,
                                         input logic [3:0]  len);
      logic       ok;
      logic [7:0] c;
      ok = (len != 4'd0) && (len <= MAX_PREFIX_LENGTH);
      for (int i = 0; i < PREFIX_SLOTS; i++) begin
         c = chars[8*i +: 8];
         if ((4'(i) < len) &&
             ((c < ASCII_FIRST_PRINT) || (c > ASCII_LAST_PRINT) ||
              ((c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)))) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   localparam logic RESET_PREFIX_OK = prefix_valid(RESET_PREFIX, RESET_PREFIX_LEN);

endpackage

`default_nettype wire

// ===== rtl/sbae_csr.sv =====
// ----------------------------------------------------------------------------
// Segwit address encoder configuration registers
// Holds the prefix characters and length, and a registered prefix check.
// ----------------------------------------------------------------------------
`default_nettype none

module sbae_csr import sbae_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata,
   output cfg_type     cfg
);

   logic [63:0] prefix_ff, prefix_in;
   logic [3:0]  len_ff, len_in;
   logic        ok_ff, ok_in;
   logic        write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      prefix_in = prefix_ff;
      len_in    = len_ff;
      if (write) begin
         unique case (csr_index)
            CSR_PREFIX_CHARACTERS: prefix_in = csr_wdata;
            CSR_PREFIX_LENGTH:     len_in    = csr_wdata[3:0];
         endcase
      end
      // check against the next values so the flag never lags the registers
      ok_in = prefix_valid(prefix_in, len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= RESET_PREFIX;
         len_ff    <= RESET_PREFIX_LEN;
         ok_ff     <= RESET_PREFIX_OK;
      end else begin
         prefix_ff <= prefix_in;
         len_ff    <= len_in;
         ok_ff     <= ok_in;
      end
   end

   assign cfg.prefix_characters = prefix_ff;
   assign cfg.prefix_length     = len_ff;
   assign cfg.prefix_ok         = ok_ff;

endmodule

`default_nettype wire

// ===== rtl/sbae_seq.sv =====
// ----------------------------------------------------------------------------
// Segwit address encoder sequencer
// Item register plus address state; one polymod step and at most one
// character per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbae_seq import sbae_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  cfg_type cfg,
   input  logic    out_ready,
   output logic    out_load,
   output rsp_type out_data
);

   logic        item_valid_ff, item_valid_in;
   req_type     item_ff, item_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [29:0] chk_ff, chk_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  nbits_ff, nbits_in;
   logic [5:0]  bcnt_ff, bcnt_in;
   logic [7:0]  version_ff, version_in;
   logic        in_addr_ff, in_addr_in;
   logic [2:0]  pend_ff, pend_in;

   logic        go, done, go_idle, req_accept;
   logic [3:0]  len_m1;
   logic [2:0]  last_idx;
   logic [7:0]  pchar;
   logic [5:0]  bcnt_inc;
   logic [2:0]  pend_new;
   logic [11:0] acc_cat;
   logic [3:0]  n_first, n_rest, nbits_m5;
   logic [4:0]  grp_first, grp_next, grp_pad;
   logic [3:0]  pad_mask;

   assign go         = item_valid_ff && out_ready;
   assign req_stall  = item_valid_ff && !(go && done);
   assign req_accept = req_valid && !req_stall;

   assign item_valid_in = req_accept ? 1'b1 : ((go && done) ? 1'b0 : item_valid_ff);
   assign item_in       = req_accept ? req_payload : item_ff;

   assign len_m1   = cfg.prefix_length - 4'd1;
   assign last_idx = len_m1[2:0];
   assign pchar    = prefix_char(cfg.prefix_characters, cnt_ff);

   assign bcnt_inc = (bcnt_ff == BYTE_COUNT_MAX) ? bcnt_ff : bcnt_ff + 6'd1;

   always_comb begin
      pend_new = pend_ff;
      if ((pend_ff == ST_OK) && (bcnt_inc > MAX_PROGRAM_BYTES)) begin
         pend_new = ST_BAD_LENGTH;
      end
      if (item_ff.final_byte && (pend_new == ST_OK) &&
          ((bcnt_inc < MIN_PROGRAM_BYTES) ||
           ((version_ff == 8'd0) && (bcnt_inc != V0_LENGTH_SHORT) &&
            (bcnt_inc != V0_LENGTH_LONG)))) begin
         pend_new = ST_BAD_LENGTH;
      end
   end

   // 8-to-5 regrouping; stale bits above the live count never reach a group
   assign acc_cat   = {acc_ff[3:0], item_ff.value};
   assign n_first   = nbits_ff + BYTE_BITS;
   assign n_rest    = n_first - GROUP_BITS;
   assign grp_first = 5'(acc_cat >> n_rest);
   assign nbits_m5  = nbits_ff - GROUP_BITS;
   assign grp_next  = 5'(acc_ff >> nbits_m5);
   assign pad_mask  = 4'((5'd1 << nbits_ff) - 5'd1);
   assign grp_pad   = 5'({1'b0, acc_ff[3:0] & pad_mask} << (GROUP_BITS - nbits_ff));

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      chk_in     = chk_ff;
      acc_in     = acc_ff;
      nbits_in   = nbits_ff;
      bcnt_in    = bcnt_ff;
      version_in = version_ff;
      in_addr_in = in_addr_ff;
      pend_in    = pend_ff;
      out_load   = 1'b0;
      out_data   = '0;
      done       = 1'b0;
      go_idle    = 1'b0;
      if (go) begin
         unique case (phase_ff)
            PH_FIRST: begin
               if (item_ff.command == CMD_START) begin
                  // restart abandons any open address
                  version_in = item_ff.value;
                  in_addr_in = 1'b1;
                  pend_in    = ST_OK;
                  bcnt_in    = '0;
                  acc_in     = '0;
                  nbits_in   = '0;
                  chk_in     = CHK_INIT;
                  if (!cfg.prefix_ok) begin
                     pend_in = ST_BAD_PREFIX;
                     done    = 1'b1;
                  end else if (item_ff.value > MAX_VERSION) begin
                     pend_in = ST_BAD_VERSION;
                     done    = 1'b1;
                  end else begin
                     chk_in = polymod_feed(CHK_INIT, 5'(pchar >> 5));
                     if (last_idx == 3'd0) begin
                        phase_in = PH_START_SEP;
                     end else begin
                        phase_in = PH_START_HI;
                        cnt_in   = 3'd1;
                     end
                  end
               end else if (!in_addr_ff) begin
                  out_load                = 1'b1;
                  out_data.character      = NULL_CHAR;
                  out_data.end_of_address = 1'b1;
                  out_data.status         = ST_NO_START;
                  done                    = 1'b1;
               end else if (pend_new != ST_OK) begin
                  bcnt_in = bcnt_inc;
                  pend_in = pend_new;
                  done    = 1'b1;
                  if (item_ff.final_byte) begin
                     out_load                = 1'b1;
                     out_data.character      = NULL_CHAR;
                     out_data.end_of_address = 1'b1;
                     out_data.status         = pend_new;
                     go_idle                 = 1'b1;
                  end
               end else begin
                  bcnt_in            = bcnt_inc;
                  acc_in             = acc_cat;
                  nbits_in           = n_rest;
                  chk_in             = polymod_feed(chk_ff, grp_first);
                  out_load           = 1'b1;
                  out_data.character = charset_char(grp_first);
                  if (n_rest >= GROUP_BITS) begin
                     phase_in = PH_GROUP;
                  end else if (item_ff.final_byte) begin
                     phase_in = (n_rest != 4'd0) ? PH_PAD : PH_ZERO;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            PH_START_HI: begin
               chk_in = polymod_feed(chk_ff, 5'(pchar >> 5));
               if (cnt_ff == last_idx) begin
                  phase_in = PH_START_SEP;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_START_SEP: begin
               chk_in   = polymod_feed(chk_ff, 5'd0);
               phase_in = PH_START_LO;
               cnt_in   = '0;
            end
            PH_START_LO: begin
               chk_in             = polymod_feed(chk_ff, pchar[4:0]);
               out_load           = 1'b1;
               out_data.character = pchar[6:0];
               if (cnt_ff == last_idx) begin
                  phase_in = PH_START_ONE;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_START_ONE: begin
               chk_in             = polymod_feed(chk_ff, version_ff[4:0]);
               out_load           = 1'b1;
               out_data.character = SEPARATOR_CHAR;
               phase_in           = PH_START_VER;
            end
            PH_START_VER: begin
               out_load           = 1'b1;
               out_data.character = charset_char(version_ff[4:0]);
               done               = 1'b1;
            end
            PH_GROUP: begin
               nbits_in           = nbits_m5;
               chk_in             = polymod_feed(chk_ff, grp_next);
               out_load           = 1'b1;
               out_data.character = charset_char(grp_next);
               if (item_ff.final_byte) begin
                  phase_in = (nbits_m5 != 4'd0) ? PH_PAD : PH_ZERO;
               end else begin
                  done = 1'b1;
               end
            end
            PH_PAD: begin
               nbits_in           = '0;
               chk_in             = polymod_feed(chk_ff, grp_pad);
               out_load           = 1'b1;
               out_data.character = charset_char(grp_pad);
               phase_in           = PH_ZERO;
               cnt_in             = '0;
            end
            PH_ZERO: begin
               if (cnt_ff == CHECK_LAST) begin
                  // fold in the bech32 or bech32m constant
                  chk_in   = polymod_feed(chk_ff, 5'd0) ^
                             ((version_ff == 8'd0) ? BECH32_CONST : BECH32M_CONST);
                  phase_in = PH_CHECK;
                  cnt_in   = '0;
               end else begin
                  chk_in = polymod_feed(chk_ff, 5'd0);
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_CHECK: begin
               out_load                = 1'b1;
               out_data.character      = charset_char(chk_ff[29:25]);
               out_data.end_of_address = (cnt_ff == CHECK_LAST);
               chk_in                  = {chk_ff[24:0], 5'd0};
               if (cnt_ff == CHECK_LAST) begin
                  done    = 1'b1;
                  go_idle = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
         if (done) begin
            phase_in = PH_FIRST;
            cnt_in   = '0;
         end
         if (go_idle) begin
            chk_in     = CHK_INIT;
            acc_in     = '0;
            nbits_in   = '0;
            bcnt_in    = '0;
            in_addr_in = 1'b0;
            pend_in    = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_FIRST;
         cnt_ff        <= '0;
         chk_ff        <= CHK_INIT;
         acc_ff        <= '0;
         nbits_ff      <= '0;
         bcnt_ff       <= '0;
         version_ff    <= '0;
         in_addr_ff    <= 1'b0;
         pend_ff       <= ST_OK;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         chk_ff        <= chk_in;
         acc_ff        <= acc_in;
         nbits_ff      <= nbits_in;
         bcnt_ff       <= bcnt_in;
         version_ff    <= version_in;
         in_addr_ff    <= in_addr_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

`ifndef SYNTHESIS
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_addr_ff |-> ((pend_ff == ST_OK) && (chk_ff == CHK_INIT) && (bcnt_ff == 6'd0)))
      else $error("address state not cleared while idle");

   a_phase_has_item: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_FIRST) |-> item_valid_ff)
      else $error("sequencer mid-item without a held transaction");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (out_load && (out_data.status != ST_OK)) |->
         (out_data.end_of_address && (out_data.character == NULL_CHAR)))
      else $error("error status on a non-terminal character");

   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_data.end_of_address) |=> !in_addr_ff)
      else $error("address still open after its last character");

   a_first_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FIRST) |-> (nbits_ff < GROUP_BITS))
      else $error("full group left over between bytes");
`endif

endmodule

`default_nettype wire

// ===== rtl/sbae_oreg.sv =====
// ----------------------------------------------------------------------------
// Segwit address encoder output register
// Holds one result transaction; reloads in the cycle it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sbae_oreg import sbae_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    can_load,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

// ===== rtl/segwit_bech32_address_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Segwit address encoder
// Streams a bech32 / bech32m segwit address as ASCII characters.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      req_type  (command, value, final_byte)
//   rsp_     out        valid / stall      rsp_type  (character, end, status)
//   csr_     in         valid / ready      index (1 bit), wdata (64 bits)
//
// One polymod step per cycle, unless a stalled result holds it. A program
// byte gives one or two characters; a final byte adds any pad, six zero steps
// and six checksum characters; a start feeds the prefix high bits in first.
// Reset (synchronous) restores the "bc" prefix and closes any open address.
// A stalled result holds the sequencer; one held input transaction waits.
// ----------------------------------------------------------------------------
`default_nettype none

module segwit_bech32_address_encoder_unit import sbae_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   cfg_type cfg;
   logic    out_ready;
   logic    out_load;
   rsp_type out_data;

   sbae_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbae_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .out_ready   (out_ready),
      .out_load    (out_load),
      .out_data    (out_data)
   );

   sbae_oreg u_oreg (
      .clock       (clock),
      .reset       (reset),
      .load        (out_load),
      .load_data   (out_data),
      .can_load    (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
